### hdl/sir_epidemic_peak_finder_top_assert.svh
// assertion macros shared by the peak finder checker
`ifndef SIR_EPIDEMIC_PEAK_FINDER_TOP_ASSERT_SVH
`define SIR_EPIDEMIC_PEAK_FINDER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SIR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define SIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sir_epk_pkg.sv
// shared types and constants for the sir epidemic peak finder
`default_nettype none
package sir_epk_pkg;

  localparam int POP_W     = 24;
  localparam int RATE_W    = 16;
  localparam int CNT_W     = 16;
  localparam int SHARE_W   = 32;
  localparam int RATE_FRAC = 12;

  // request payload
  typedef struct packed {
    logic [POP_W-1:0]  population;
    logic [RATE_W-1:0] infect_rate;
    logic [RATE_W-1:0] recover_rate;
    logic [CNT_W-1:0]  step_count;
  } sir_epk_in_t;

  // result payload
  typedef struct packed {
    logic                      status;
    logic [CNT_W-1:0]          peak_step;
    logic signed [SHARE_W-1:0] peak_susceptible;
    logic signed [SHARE_W-1:0] peak_infected;
    logic signed [SHARE_W-1:0] peak_recovered;
  } sir_epk_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic init;
    logic mul;
    logic ap;
    logic upd;
  } sir_epk_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic err;
    logic div_last;
    logic last_step;
  } sir_epk_stat_t;

endpackage
`default_nettype wire

### hdl/sir_epidemic_peak_finder_top.sv
// top level of the sir epidemic peak finder
//
//   channel   direction  handshake            payload
//   request   in         start && !busy       sir_epk_in_t
//   result    out        done (one cycle)     sir_epk_out_t
//
// a good request runs the divider and then K update steps before done,
// K being step_count clamped to 2^STEP_BITS - 1; a request with any zero
// field reports from the divide state. the divider runs one quotient bit
// per cycle, then each step goes through the multiply, ap and update states.
// reset is synchronous and returns the controller to idle with busy low.
// the receiver cannot stall: the result is valid only in the done cycle.
`default_nettype none
module sir_epidemic_peak_finder_top
  import sir_epk_pkg::*;
#(
  parameter int STEP_BITS = 16,
  parameter int FRAC_BITS = 29
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire sir_epk_in_t request,
  output logic             done,
  output sir_epk_out_t     result
);

  sir_epk_cmd_t  cmd;
  sir_epk_stat_t stat;

  // sequencer
  sir_epk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic and storage
  sir_epk_dp #(
    .STEP_BITS (STEP_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule
`default_nettype wire

### hdl/sir_epk_ctrl.sv
// controller state machine for the peak finder
`default_nettype none
module sir_epk_ctrl
  import sir_epk_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire sir_epk_stat_t stat,
  output sir_epk_cmd_t       cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_MUL,
    ST_AP,
    ST_UPD
  } state_t;

  state_t state;

  // state, busy flag and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_DIV;
            busy  <= 1'b1;
          end
        end
        ST_DIV: begin
          if (stat.err) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else if (stat.div_last) begin
            state <= ST_INIT;
          end
        end
        ST_INIT: state <= ST_MUL;
        ST_MUL:  state <= ST_AP;
        ST_AP:   state <= ST_UPD;
        ST_UPD: begin
          if (stat.last_step) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd.load     = (state == ST_IDLE) && start;
    cmd.div_step = (state == ST_DIV);
    cmd.init     = (state == ST_INIT);
    cmd.mul      = (state == ST_MUL);
    cmd.ap       = (state == ST_AP);
    cmd.upd      = (state == ST_UPD);
  end

endmodule
`default_nettype wire

### hdl/sir_epk_dp.sv
// datapath: reciprocal divider, sir update multipliers and peak tracking
`default_nettype none
module sir_epk_dp
  import sir_epk_pkg::*;
#(
  parameter int STEP_BITS = 16,
  parameter int FRAC_BITS = 29
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sir_epk_in_t  request,
  input  wire sir_epk_cmd_t cmd,
  output sir_epk_stat_t     stat,
  output sir_epk_out_t      result
);

  localparam int DCW   = $clog2(FRAC_BITS + 1);
  localparam int PROD_W = 2 * SHARE_W;
  localparam int BY_W  = RATE_W + 1 + SHARE_W;
  localparam int P_W   = PROD_W - FRAC_BITS;
  localparam int AP_W  = RATE_W + 1 + P_W;
  localparam int UW    = AP_W + 2;
  localparam logic [32:0] STEP_MAX = (33'd1 << STEP_BITS) - 33'd1;
  localparam logic [32:0] ONE_F    = 33'd1 << FRAC_BITS;

  // captured request
  logic [POP_W-1:0]     n_reg;
  logic [RATE_W-1:0]    a_reg;
  logic [RATE_W-1:0]    b_reg;
  logic [STEP_BITS-1:0] k_reg;
  logic                 err;

  // divider
  logic [POP_W-1:0]   rem;
  logic [FRAC_BITS:0] quo;
  logic [DCW-1:0]     div_cnt;
  logic [POP_W:0]     rem_sh;
  logic [POP_W:0]     rem_diff;
  logic               rem_ge;
  logic [32:0]        s_init;

  // running shares and peak
  logic signed [SHARE_W-1:0] s;
  logic signed [SHARE_W-1:0] y;
  logic signed [SHARE_W-1:0] r;
  logic [STEP_BITS-1:0]      step_cnt;
  logic signed [SHARE_W-1:0] best_inf;
  logic signed [SHARE_W-1:0] best_s;
  logic signed [SHARE_W-1:0] best_r;
  logic [STEP_BITS-1:0]      best_step;

  // update pipeline
  logic signed [PROD_W-1:0] prod_sy;
  logic signed [BY_W-1:0]   prod_by;
  logic signed [AP_W-1:0]   prod_ap;
  logic signed [PROD_W-1:0] p_full;
  logic signed [P_W-1:0]    p_val;
  logic signed [AP_W-1:0]   asy_full;
  logic signed [BY_W-1:0]   by_full;
  logic signed [UW-1:0]     asy_ext;
  logic signed [UW-1:0]     by_ext;
  logic signed [UW-1:0]     s_new;
  logic signed [UW-1:0]     y_new;
  logic signed [UW-1:0]     r_new;
  logic [STEP_BITS-1:0]     k_sat;

  function automatic logic signed [SHARE_W-1:0] sat32(input logic signed [UW-1:0] v);
    logic [UW-SHARE_W:0] top;
    top = v[UW-1:SHARE_W-1];
    if (top == '0 || top == '1) begin
      return v[SHARE_W-1:0];
    end else if (v[UW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // step count clamp to counter range
  always_comb begin
    if ({17'd0, request.step_count} > STEP_MAX) begin
      k_sat = '1;
    end else begin
      k_sat = STEP_BITS'(request.step_count);
    end
  end

  // restoring divide of 2^F by n, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, (div_cnt == DCW'(FRAC_BITS))};
    rem_diff = rem_sh - {1'b0, n_reg};
    rem_ge   = (rem_sh >= {1'b0, n_reg});
    s_init   = ONE_F - 33'(quo) - {32'd0, (rem != '0)};
  end

  // update arithmetic
  always_comb begin
    p_full   = prod_sy >>> FRAC_BITS;
    p_val    = p_full[P_W-1:0];
    asy_full = prod_ap >>> RATE_FRAC;
    by_full  = prod_by >>> RATE_FRAC;
    asy_ext  = UW'(asy_full);
    by_ext   = UW'(by_full);
    s_new    = UW'(s) - asy_ext;
    y_new    = UW'(y) + asy_ext - by_ext;
    r_new    = UW'(r) + by_ext;
  end

  // request capture and error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      err     <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.load) begin
      n_reg   <= request.population;
      a_reg   <= request.infect_rate;
      b_reg   <= request.recover_rate;
      k_reg   <= k_sat;
      err     <= (request.population == '0) || (request.infect_rate == '0) ||
                 (request.recover_rate == '0) || (request.step_count == '0);
      rem     <= '0;
      quo     <= '0;
      div_cnt <= DCW'(FRAC_BITS);
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? rem_diff[POP_W-1:0] : rem_sh[POP_W-1:0];
      quo     <= {quo[FRAC_BITS-1:0], rem_ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // shares, products and peak tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.init) begin
      s         <= s_init[SHARE_W-1:0];
      y         <= SHARE_W'(quo);
      r         <= '0;
      step_cnt  <= '0;
      best_inf  <= '0;
      best_step <= '0;
      best_s    <= s_init[SHARE_W-1:0];
      best_r    <= '0;
    end else if (cmd.mul) begin
      prod_sy <= s * y;
      prod_by <= $signed({1'b0, b_reg}) * y;
      if (y > best_inf) begin
        best_inf  <= y;
        best_step <= step_cnt;
        best_s    <= s;
        best_r    <= r;
      end
    end else if (cmd.ap) begin
      prod_ap <= $signed({1'b0, a_reg}) * p_val;
    end else if (cmd.upd) begin
      s        <= sat32(s_new);
      y        <= sat32(y_new);
      r        <= sat32(r_new);
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // status to controller
  always_comb begin
    stat.err       = err;
    stat.div_last  = (div_cnt == '0);
    stat.last_step = (step_cnt == (k_reg - 1'b1));
  end

  // result fields, cleared on a parameter error
  always_comb begin
    result.status = err;
    if (err) begin
      result.peak_step        = '0;
      result.peak_susceptible = '0;
      result.peak_infected    = '0;
      result.peak_recovered   = '0;
    end else begin
      result.peak_step        = CNT_W'(best_step);
      result.peak_susceptible = best_s;
      result.peak_infected    = best_inf;
      result.peak_recovered   = best_r;
    end
  end

endmodule
`default_nettype wire

### hdl/sir_epk_checker.sv
// port-level checks for the peak finder, bound to the top level
`default_nettype none
module sir_epk_checker
  import sir_epk_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         start,
  input wire logic         busy,
  input wire logic         done,
  input wire sir_epk_out_t result
);

`include "sir_epidemic_peak_finder_top_assert.svh"

  // result transfer ends the job
  `SIR_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "done while busy")

  // an accepted request makes the block busy
  `SIR_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "request not taken")

  // one result per request, never two in a row
  `SIR_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held")

  // error results carry zero fields
  `SIR_ASSERT_SAME(a_err_zero, clk, rst, done && result.status,
    result.peak_step == '0 && result.peak_susceptible == '0 &&
    result.peak_infected == '0 && result.peak_recovered == '0,
    "error result not cleared")

endmodule

bind sir_epidemic_peak_finder_top sir_epk_checker u_sir_epk_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
